// File: rtl/majority_third_vote_assert.svh
// assertion macros shared by the majority vote checker
`ifndef MAJORITY_THIRD_VOTE_ASSERT_SVH
`define MAJORITY_THIRD_VOTE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MTV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MTV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mtv_pkg.sv
// types and constants for the n/3 majority vote block
`default_nettype none

package mtv_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

  // one element request
  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] element;
    logic                            last;
  } mtv_in_t;

  // one result request
  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] majority_value;
    logic                            found;
    logic                            overflow;
    logic                            final_res;
  } mtv_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic emit_first;
    logic emit_second;
    logic clear;
  } mtv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_free;
    logic scan_last;
    logic ok_a;
    logic ok_b;
  } mtv_sts_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_TAIL,
    S_RES1,
    S_RES2
  } mtv_state_t;

endpackage

`default_nettype wire

// File: rtl/majority_third_vote.sv
// Finds every value that occurs more than n/3 times in a set of signed
// elements. Elements are taken one per cycle while the block loads a set;
// each is written to an internal store of MAX_ELEMENTS words and runs through
// the two-candidate vote as it arrives. Elements beyond capacity are dropped
// and every result of that set is marked overflow. After the element marked
// last, the input stalls while one pass over the store recounts both
// candidates, one word per cycle from the store's single read port.
// Then one or two results follow, one per cycle while the output is not
// stalled, candidate a first, or a single not-found result. With no gaps
// on the input and no output stall, throughput is bounded by the recount
// pass through the store. The next set's elements are accepted while the
// final result still waits in the output register.
`default_nettype none

module majority_third_vote #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             elem_valid,
  output logic                  elem_stall,
  input  wire mtv_pkg::mtv_in_t elem,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output mtv_pkg::mtv_out_t     res
);
  import mtv_pkg::*;

  mtv_cmd_t cmd;
  mtv_sts_t sts;

  // sequencer
  mtv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_last  (elem.last),
    .elem_stall (elem_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // store, vote and result register
  mtv_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// File: rtl/mtv_ctrl.sv
// sequencer for load, recount pass and result emission
`default_nettype none

module mtv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             elem_valid,
  input  wire logic             elem_last,
  output logic                  elem_stall,
  input  wire mtv_pkg::mtv_sts_t sts,
  output mtv_pkg::mtv_cmd_t     cmd
);
  import mtv_pkg::*;

  mtv_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    elem_stall = 1'b1;
    unique case (state)
      S_LOAD: begin
        elem_stall = 1'b0;
        if (elem_valid) begin
          cmd.load = 1'b1;
          if (elem_last) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        // last read word is being counted
        state_next = S_RES1;
      end
      S_RES1: begin
        if (sts.res_free) begin
          cmd.emit_first = 1'b1;
          if (sts.ok_a && sts.ok_b) begin
            state_next = S_RES2;
          end else begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_RES2: begin
        if (sts.res_free) begin
          cmd.emit_second = 1'b1;
          cmd.clear       = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mtv_dp.sv
// element store, two-candidate vote, recount counters and result register
`default_nettype none

module mtv_dp #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtv_pkg::mtv_in_t  elem,
  input  wire mtv_pkg::mtv_cmd_t cmd,
  output mtv_pkg::mtv_sts_t      sts,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output mtv_pkg::mtv_out_t      res
);
  import mtv_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = $clog2(MAX_ELEMENTS);

  logic [ELEMENT_WIDTH-1:0] mem [MAX_ELEMENTS];

  logic signed [ELEMENT_WIDTH-1:0] cand_a, cand_b, cand_a_next, cand_b_next;
  logic [CW-1:0] tally_a, tally_b, tally_a_next, tally_b_next;
  logic [CW-1:0] count;
  logic          overflow_seen;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic signed [ELEMENT_WIDTH-1:0] rd_data;
  logic [CW-1:0] cnt_a, cnt_b;
  logic          full;
  logic [CW+1:0] three_a, three_b;

  assign full = (count == CW'(MAX_ELEMENTS));

  // vote step on the incoming element
  always_comb begin
    cand_a_next  = cand_a;
    cand_b_next  = cand_b;
    tally_a_next = tally_a;
    tally_b_next = tally_b;
    priority if (tally_a == '0 && cand_b != elem.element) begin
      cand_a_next  = elem.element;
      tally_a_next = CW'(1);
    end else if (tally_b == '0 && cand_a != elem.element) begin
      cand_b_next  = elem.element;
      tally_b_next = CW'(1);
    end else if (elem.element == cand_a) begin
      tally_a_next = tally_a + CW'(1);
    end else if (elem.element == cand_b) begin
      tally_b_next = tally_b + CW'(1);
    end else begin
      tally_a_next = tally_a - CW'(1);
      tally_b_next = tally_b - CW'(1);
    end
  end

  // element store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= elem.element;
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[rd_idx];
    end
  end

  // set state: candidates, tallies, fill count, recount counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cand_a        <= ELEM_MIN;
      cand_b        <= ELEM_MIN;
      tally_a       <= '0;
      tally_b       <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
      rd_idx        <= '0;
      rd_vld        <= 1'b0;
      cnt_a         <= '0;
      cnt_b         <= '0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.load) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count   <= count + CW'(1);
          cand_a  <= cand_a_next;
          cand_b  <= cand_b_next;
          tally_a <= tally_a_next;
          tally_b <= tally_b_next;
        end
      end
      if (cmd.scan_rd) begin
        rd_idx <= rd_idx + AW'(1);
      end
      // recount, candidate a takes precedence
      if (rd_vld) begin
        if (rd_data == cand_a) begin
          cnt_a <= cnt_a + CW'(1);
        end else if (rd_data == cand_b) begin
          cnt_b <= cnt_b + CW'(1);
        end
      end
    end
  end

  // count > n/3 checked as 3*count > n
  assign three_a = (CW+2)'(cnt_a) + ((CW+2)'(cnt_a) << 1);
  assign three_b = (CW+2)'(cnt_b) + ((CW+2)'(cnt_b) << 1);

  assign sts.ok_a      = three_a > (CW+2)'(count);
  assign sts.ok_b      = three_b > (CW+2)'(count);
  assign sts.scan_last = (CW'(rd_idx) + CW'(1)) == count;
  assign sts.res_free  = !res_valid || !res_stall;

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_first || cmd.emit_second) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      res.majority_value <= sts.ok_a ? cand_a : (sts.ok_b ? cand_b : '0);
      res.found          <= sts.ok_a || sts.ok_b;
      res.overflow       <= overflow_seen;
      res.final_res      <= !(sts.ok_a && sts.ok_b);
    end else if (cmd.emit_second) begin
      res.majority_value <= cand_b;
      res.found          <= 1'b1;
      res.overflow       <= overflow_seen;
      res.final_res      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtv_checker.sv
// port-level checks for the majority vote block and their bind
`default_nettype none
`include "majority_third_vote_assert.svh"

module mtv_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              elem_valid,
  input wire logic              elem_stall,
  input wire mtv_pkg::mtv_in_t  elem,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire mtv_pkg::mtv_out_t res
);
  import mtv_pkg::*;

  // a stalled result holds
  `MTV_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

  // a not-found result ends the set and carries zero
  `MTV_ASSERT_NOW(a_none_final, res_valid && !res.found, res.final_res && res.majority_value == '0, "bad not-found result")

  // input stalls while the recount runs
  `MTV_ASSERT_NEXT(a_scan_stall, elem_valid && !elem_stall && elem.last, elem_stall, "element taken during recount")

  // the second result follows at once with a different value
  `MTV_ASSERT_NEXT(a_second, res_valid && !res_stall && !res.final_res, res_valid && res.found && res.final_res && res.majority_value != $past(res.majority_value), "second result missing or repeated")

endmodule

bind majority_third_vote mtv_checker u_chk (.*);

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the n/3 majority vote block
`timescale 1ns / 100ps

module tb_top;
  import mtv_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PERCENT = 19;
  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};

  logic     clk;
  logic     rst = 1'b1;
  logic     elem_valid = 1'b0;
  logic     elem_stall;
  mtv_in_t  elem = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  mtv_out_t res;

  majority_third_vote #(.MAX_ELEMENTS(CAPACITY)) dut (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // vote state mirrored from the block
  logic signed [ELEMENT_WIDTH-1:0] set_store [CAPACITY];
  logic signed [ELEMENT_WIDTH-1:0] cand_a, cand_b;
  int       tally_a, tally_b, stored_count;
  bit       dropped_any;
  mtv_out_t expected_winners[$];
  logic signed [ELEMENT_WIDTH-1:0] set_buf[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit burst_pending = 1'b0;
  int hold_left = 0;

  function automatic mtv_out_t make_result(logic signed [ELEMENT_WIDTH-1:0] v, bit hit, bit fin);
    mtv_out_t r;
    r.majority_value = v;
    r.found = hit;
    r.overflow = dropped_any;
    r.final_res = fin;
    return r;
  endfunction

  // append one expected result request
  function automatic void expect_result(mtv_out_t r);
    expected_winners = {expected_winners, r};
  endfunction

  // append one element to the set being built
  function automatic void add_to_set(logic signed [ELEMENT_WIDTH-1:0] v);
    set_buf = {set_buf, v};
  endfunction

  function automatic void clear_vote();
    cand_a = ELEM_MIN;
    cand_b = ELEM_MIN;
    tally_a = 0;
    tally_b = 0;
    stored_count = 0;
    dropped_any = 1'b0;
  endfunction

  // vote on one accepted element; on the last one recount and queue the winners
  function automatic void absorb_element(logic signed [ELEMENT_WIDTH-1:0] x, logic lst);
    int cnt_a, cnt_b, need;
    bit ok_a, ok_b;
    cnt_a = 0;
    cnt_b = 0;
    if (stored_count < CAPACITY) begin
      set_store[stored_count] = x;
      stored_count++;
      if (tally_a == 0 && cand_b != x) begin
        cand_a = x;
        tally_a = 1;
      end else if (tally_b == 0 && cand_a != x) begin
        cand_b = x;
        tally_b = 1;
      end else if (x == cand_a) begin
        tally_a++;
      end else if (x == cand_b) begin
        tally_b++;
      end else begin
        tally_a--;
        tally_b--;
      end
    end else begin
      dropped_any = 1'b1;
    end
    if (!lst) return;
    // recount pass; equal candidates credit only a
    for (int i = 0; i < stored_count; i++) begin
      if (set_store[i] == cand_a) cnt_a++;
      else if (set_store[i] == cand_b) cnt_b++;
    end
    need = stored_count / 3 + 1;
    ok_a = cnt_a >= need;
    ok_b = cnt_b >= need;
    if (ok_a && ok_b) begin
      expect_result(make_result(cand_a, 1'b1, 1'b0));
      expect_result(make_result(cand_b, 1'b1, 1'b1));
    end else if (ok_a) begin
      expect_result(make_result(cand_a, 1'b1, 1'b1));
    end else if (ok_b) begin
      expect_result(make_result(cand_b, 1'b1, 1'b1));
    end else begin
      expect_result(make_result('0, 1'b0, 1'b1));
    end
    clear_vote();
  endfunction

  initial clear_vote();

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (burst_pending) begin
      burst_pending = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (steady) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    mtv_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_winners.size() == 0) begin
        $error("unexpected result: value %0d found %0b", res.majority_value, res.found);
        mismatch_count++;
      end else begin
        want = expected_winners.pop_front();
        if (res.majority_value !== want.majority_value) begin
          $error("majority_value: expected %0d, got %0d", want.majority_value,
                 res.majority_value);
          mismatch_count++;
        end
        if (res.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, res.found);
          mismatch_count++;
        end
        if (res.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, res.overflow);
          mismatch_count++;
        end
        if (res.final_res !== want.final_res) begin
          $error("final_res: expected %0b, got %0b", want.final_res, res.final_res);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // offer one element request and wait until it is taken
  task automatic send_element(logic signed [ELEMENT_WIDTH-1:0] v, logic lst);
    mtv_in_t item;
    item.element = v;
    item.last = lst;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        elem_valid <= 1'b0;
        @(posedge clk);
      end
    end
    elem_valid <= 1'b1;
    elem <= item;
    do @(posedge clk); while (elem_stall);
    absorb_element(v, lst);
  endtask

  // send set_buf as one set, last flag on its final element
  task automatic send_set();
    for (int i = 0; i < set_buf.size(); i++)
      send_element(set_buf[i], i == set_buf.size() - 1);
    set_buf.delete();
  endtask

  task automatic drop_and_drain();
    elem_valid <= 1'b0;
    @(posedge clk);
    while (expected_winners.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ELEMENT_WIDTH-1:0] random_element();
    case ($urandom_range(9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // fill set_buf with n elements mostly drawn from a small pool of values
  task automatic build_set(int n, bit min_in_pool);
    logic signed [ELEMENT_WIDTH-1:0] pool [3];
    int k;
    k = $urandom_range(1, 3);
    foreach (pool[i]) pool[i] = ($urandom_range(1) == 0) ? random_element()
                                                         : $urandom_range(15);
    if (min_in_pool) pool[0] = ELEM_MIN;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) add_to_set(pool[$urandom_range(k - 1)]);
      else add_to_set(random_element());
    end
  endtask

  // extremes, one or two winners, none found, equal candidates at reset value
  task automatic test_directed_extremes();
    set_buf = '{ELEM_MAX};
    send_set();
    set_buf = '{ELEM_MIN};
    send_set();
    set_buf = '{32'sd0, -32'sd1};
    send_set();
    set_buf = '{32'sd1, 32'sd2, 32'sd3};
    send_set();
    set_buf = '{-32'sd1, -32'sd1, 32'sd5, 32'sd5, 32'sd7};
    send_set();
    set_buf = '{ELEM_MIN, ELEM_MIN, 32'sd7, ELEM_MIN};
    send_set();
    set_buf = '{32'sh55555555, 32'shAAAAAAAA, 32'sh55555555};
    send_set();
    set_buf = '{32'sd5, ELEM_MIN};
    send_set();
    drop_and_drain();
  endtask

  // store fills completely, then further elements are dropped; last one among them
  task automatic test_store_overflow();
    build_set(CAPACITY + 3, 1'b0);
    send_set();
    drop_and_drain();
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_output_hold_off();
    burst_pending = 1'b1;
    for (int s = 0; s < 40; s++) begin
      build_set($urandom_range(1, 4), 1'b0);
      send_set();
    end
    drop_and_drain();
  endtask

  // random sets, mostly small with a few larger ones, one stretch with no idling
  task automatic test_random_sets();
    int items;
    int sets;
    int n;
    int style;
    items = 0;
    sets = 0;
    while (items < RANDOM_ITEMS) begin
      steady = (sets >= 6 && sets < 14);
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      style = $urandom_range(9);
      if (style == 7) begin
        for (int i = 0; i < n; i++) add_to_set(random_element());
      end else begin
        build_set(n, style >= 8);
      end
      send_set();
      items += n;
      sets++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    test_directed_extremes();
    test_store_overflow();
    test_output_hold_off();
    test_random_sets();
    drop_and_drain();
    repeat (50) @(posedge clk);
    if (expected_winners.size() != 0) begin
      $error("%0d expected results never arrived", expected_winners.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
